@@ sv/kvm_pkg.sv @@
// Shared types, command codes and register indexes of the keyframe vertex morph block.
package kvm_pkg;

	typedef logic [23:0] coord_t;
	typedef coord_t [2:0] vec3_t;

	typedef enum logic [2:0] {
		CMD_LOAD_VERTEX   = 3'd0,
		CMD_LOAD_TEXCOORD = 3'd1,
		CMD_LOAD_TRIANGLE = 3'd2,
		CMD_BEGIN_PASS    = 3'd3,
		CMD_END_PASS      = 3'd4,
		CMD_DRAW          = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		REG_START_FRAME = 2'd0,
		REG_END_FRAME   = 2'd1,
		REG_FRAME_COUNT = 2'd2,
		REG_BLEND_STEP  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic        degen;
	} norm_res_t;

	localparam int DEF_FRAMES    = 32;
	localparam int DEF_VERTICES  = 512;
	localparam int DEF_TRIANGLES = 2048;
	localparam int DEF_TEXCOORDS = 1024;

	localparam logic [17:0] BLEND_ONE = 18'd65536;
	localparam logic [17:0] BLEND_MAX = 18'h3FFFF;

endpackage

@@ sv/kvm_lane.sv @@
// One corner lane: blends a vertex between two keyframes on all three axes.
module kvm_lane
	import kvm_pkg::*;
(
	input  logic        clk,
	input  logic [17:0] blend,
	input  vec3_t       p1,
	input  vec3_t       p2,
	output vec3_t       pos
);

	logic signed [43:0] prod_s1 [3];
	logic signed [23:0] base_s1 [3];
	vec3_t              pos_s2;

	always_ff @(posedge clk) begin
		for (int g = 0; g < 3; g++) begin
			prod_s1[g] <= ($signed({p2[g][23], p2[g]}) - $signed({p1[g][23], p1[g]}))
				* $signed({1'b0, blend});
			base_s1[g] <= $signed(p1[g]);
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < 3; g++) begin
			logic signed [43:0] t;
			logic signed [44:0] r;
			t = prod_s1[g] + 44'sd32768;
			r = {{21{base_s1[g][23]}}, base_s1[g]} + {t[43], (t >>> 16)};
			if (r > 45'sd8388607)
				pos_s2[g] <= 24'h7FFFFF;
			else if (r < -45'sd8388608)
				pos_s2[g] <= 24'h800000;
			else
				pos_s2[g] <= r[23:0];
		end
	end

	assign pos = pos_s2;

endmodule

@@ sv/kvm_norm.sv @@
// Merging stage: cross product of the three blended corners and its unit normal.
module kvm_norm
	import kvm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  vec3_t     p0,
	input  vec3_t     p1,
	input  vec3_t     p2,
	output logic      done,
	output norm_res_t res
);

	typedef enum logic [6:0] {
		N_IDLE  = 7'b0000001,
		N_MUL   = 7'b0000010,
		N_MAG   = 7'b0000100,
		N_SHIFT = 7'b0001000,
		N_SQ    = 7'b0010000,
		N_SQRT  = 7'b0100000,
		N_DIV   = 7'b1000000
	} nstate_t;

	nstate_t            state_q;
	logic [5:0]         cnt_q;
	logic [1:0]         comp_q;
	logic signed [24:0] a_q [3];
	logic signed [24:0] b_q [3];
	logic signed [49:0] prod_q;
	logic signed [51:0] c_q [3];
	logic [50:0]        mag_q [3];
	logic [2:0]         neg_q;
	logic [59:0]        sq_q;
	logic [61:0]        sum_q;
	logic [63:0]        n_q, root_q, bit_q;
	logic [30:0]        rem_q;
	logic [44:0]        dq_q;
	logic [15:0]        nrm_q [3];
	logic               degen_q, done_q;
	logic signed [24:0] opa, opb;
	logic [31:0]        trial;
	logic               ge;

	always_comb begin
		case (cnt_q[2:0])
			3'd0: begin opa = a_q[1]; opb = b_q[2]; end
			3'd1: begin opa = b_q[1]; opb = a_q[2]; end
			3'd2: begin opa = b_q[0]; opb = a_q[2]; end
			3'd3: begin opa = a_q[0]; opb = b_q[2]; end
			3'd4: begin opa = a_q[0]; opb = b_q[1]; end
			default: begin opa = b_q[0]; opb = a_q[1]; end
		endcase
	end

	assign trial = {rem_q, dq_q[44]};
	assign ge    = trial >= {1'b0, root_q[30:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
			comp_q  <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				N_IDLE: begin
					if (start) begin
						state_q <= N_MUL;
						cnt_q   <= '0;
					end
				end
				N_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd6)
						state_q <= N_MAG;
				end
				N_MAG: state_q <= N_SHIFT;
				N_SHIFT: begin
					if (mag_q[0][50:30] == '0 && mag_q[1][50:30] == '0
						&& mag_q[2][50:30] == '0) begin
						state_q <= N_SQ;
						cnt_q   <= '0;
					end
				end
				N_SQ: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd3) begin
						cnt_q <= '0;
						if (sum_q + {2'b0, sq_q} == '0) begin
							state_q <= N_IDLE;
							done_q  <= 1'b1;
						end else begin
							state_q <= N_SQRT;
						end
					end
				end
				N_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						state_q <= N_DIV;
						cnt_q   <= '0;
						comp_q  <= '0;
					end
				end
				N_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd45) begin
						cnt_q  <= '0;
						comp_q <= comp_q + 2'd1;
						if (comp_q == 2'd2) begin
							state_q <= N_IDLE;
							done_q  <= 1'b1;
						end
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					for (int j = 0; j < 3; j++) begin
						a_q[j] <= $signed({p0[j][23], p0[j]}) - $signed({p2[j][23], p2[j]});
						b_q[j] <= $signed({p0[j][23], p0[j]}) - $signed({p1[j][23], p1[j]});
					end
				end
			end
			N_MUL: begin
				if (cnt_q < 6'd6)
					prod_q <= opa * opb;
				if (cnt_q != 6'd0) begin
					if (cnt_q[0])
						c_q[2'((cnt_q - 6'd1) >> 1)] <= {{2{prod_q[49]}}, prod_q};
					else
						c_q[2'((cnt_q - 6'd1) >> 1)] <= c_q[2'((cnt_q - 6'd1) >> 1)]
							- {{2{prod_q[49]}}, prod_q};
				end
			end
			N_MAG: begin
				for (int j = 0; j < 3; j++) begin
					neg_q[j] <= c_q[j][51];
					mag_q[j] <= c_q[j][51] ? 51'(-c_q[j]) : c_q[j][50:0];
				end
			end
			N_SHIFT: begin
				sum_q <= '0;
				if (!(mag_q[0][50:30] == '0 && mag_q[1][50:30] == '0
					&& mag_q[2][50:30] == '0)) begin
					for (int j = 0; j < 3; j++)
						mag_q[j] <= mag_q[j] >> 1;
				end
			end
			N_SQ: begin
				if (cnt_q < 6'd3)
					sq_q <= mag_q[cnt_q[1:0]][29:0] * mag_q[cnt_q[1:0]][29:0];
				if (cnt_q != 6'd0)
					sum_q <= sum_q + {2'b0, sq_q};
				if (cnt_q == 6'd3) begin
					degen_q <= (sum_q + {2'b0, sq_q} == '0);
					n_q     <= {2'b0, sum_q + {2'b0, sq_q}};
					root_q  <= '0;
					bit_q   <= 64'h4000_0000_0000_0000;
					for (int j = 0; j < 3; j++)
						nrm_q[j] <= '0;
				end
			end
			N_SQRT: begin
				// The first dividend is built from the root as it stands after this step.
				if (n_q >= root_q + bit_q) begin
					n_q    <= n_q - (root_q + bit_q);
					root_q <= (root_q >> 1) + bit_q;
					dq_q   <= {1'b0, mag_q[0][29:0], 14'd0}
						+ 45'(((root_q >> 1) + bit_q) >> 1);
				end else begin
					root_q <= root_q >> 1;
					dq_q   <= {1'b0, mag_q[0][29:0], 14'd0} + 45'(root_q >> 2);
				end
				bit_q <= bit_q >> 2;
				rem_q <= '0;
			end
			N_DIV: begin
				if (cnt_q < 6'd45) begin
					rem_q <= ge ? 31'(trial - {1'b0, root_q[30:0]}) : trial[30:0];
					dq_q  <= {dq_q[43:0], ge};
				end else begin
					nrm_q[comp_q] <= neg_q[comp_q] ? 16'(-dq_q[15:0]) : dq_q[15:0];
					rem_q <= '0;
					dq_q  <= {1'b0, mag_q[(comp_q == 2'd2) ? 2'd0 : comp_q + 2'd1][29:0], 14'd0}
						+ 45'(root_q[30:0] >> 1);
				end
			end
			default: ;
		endcase
	end

	assign done      = done_q;
	assign res.nx    = nrm_q[0];
	assign res.ny    = nrm_q[1];
	assign res.nz    = nrm_q[2];
	assign res.degen = degen_q;

endmodule

@@ sv/keyframe_vertex_morph_normal.sv @@
// Top level of the keyframe vertex morph block with triangle normals.
//
// Usage: items arrive on the input channel (in_valid / in_stall) and results
// leave on the output channel (out_valid / out_stall); a transfer happens at
// a rising edge with valid high and stall low. Load commands write the vertex,
// texcoord or triangle memories and give no result; an end-pass adds the blend
// step. A begin-pass checks the frame range, may advance the keyframes and
// returns one result carrying status. A draw returns three results, corners
// 0, 2, 1, each with the blended position, texcoord and shared unit normal.
// Flow: a draw or begin-pass holds in_stall high until its last result is
// registered, so no new item is taken before then. A draw gives one result per
// cycle while the receiver does not stall. Most of a draw's time goes to the
// normal unit: six serial products for the cross product, scaling shifts, 32
// square-root steps and three divisions, after one triangle read, six vertex
// reads through the single vertex memory port and two lerp stages.
// After reset the frames are 0 and 1 and the blend is zero; memories hold no
// defined data until loaded. While the receiver stalls the output register
// holds its result; while idle the block still takes loads, draws and begin-passes.
// The APB port writes start_frame, end_frame, frame_count and blend_step.
module keyframe_vertex_morph_normal
	import kvm_pkg::*;
#(
	parameter int FRAMES    = DEF_FRAMES,
	parameter int VERTICES  = DEF_VERTICES,
	parameter int TRIANGLES = DEF_TRIANGLES,
	parameter int TEXCOORDS = DEF_TEXCOORDS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [4:0]  frame,
	input  logic [10:0] index,
	input  logic [23:0] value_x,
	input  logic [23:0] value_y,
	input  logic [23:0] value_z,
	input  logic [8:0]  vert_a,
	input  logic [8:0]  vert_b,
	input  logic [8:0]  vert_c,
	input  logic [9:0]  tex_a,
	input  logic [9:0]  tex_b,
	input  logic [9:0]  tex_c,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [23:0] pos_x,
	output logic [23:0] pos_y,
	output logic [23:0] pos_z,
	output logic [15:0] tex_s,
	output logic [15:0] tex_t,
	output logic [15:0] norm_x,
	output logic [15:0] norm_y,
	output logic [15:0] norm_z,
	output logic        degenerate,
	output logic        status,
	output logic        last
);

	localparam int VAW = (FRAMES * VERTICES > 1) ? $clog2(FRAMES * VERTICES) : 1;
	localparam int TAW = (TRIANGLES > 1) ? $clog2(TRIANGLES) : 1;
	localparam int CAW = (TEXCOORDS > 1) ? $clog2(TEXCOORDS) : 1;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_TRI   = 7'b0000010,
		S_FETCH = 7'b0000100,
		S_LERP  = 7'b0001000,
		S_NORM  = 7'b0010000,
		S_EMIT  = 7'b0100000,
		S_BEGIN = 7'b1000000
	} state_t;

	// Configuration registers.
	logic [4:0]  start_frame_q, end_frame_q;
	logic [5:0]  frame_count_q;
	logic [16:0] blend_step_q;
	logic        cfg_wr;

	// Animation state.
	logic [4:0]  cur_frame_q, nxt_frame_q;
	logic [17:0] blend_q;

	// Memories and their registered read data.
	logic [71:0] vmem [FRAMES * VERTICES];
	logic [31:0] cmem [TEXCOORDS];
	logic [56:0] tmem [TRIANGLES];
	logic [71:0] vrd_q;
	logic [31:0] crd_q;
	logic [56:0] trd_q;
	logic        vok_q, cok_q;

	state_t      state_q;
	logic [2:0]  cnt_q;
	logic [1:0]  ecnt_q;
	logic        status_q;
	logic [56:0] tri_q;
	vec3_t       p1_q [3];
	vec3_t       p2_q [3];
	vec3_t       pos [3];
	logic [31:0] tc_q [3];
	logic        norm_start_q;
	logic        norm_done;
	norm_res_t   nres;
	logic        accept, out_free;

	logic [VAW-1:0] vaddr;
	logic           vok;
	logic [8:0]     fetch_vert;
	logic [4:0]     fetch_frame;
	logic [9:0]     fetch_tex;
	logic [1:0]     corner;

	assign cfg_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		case (paddr[3:2])
			REG_START_FRAME: prdata = {27'd0, start_frame_q};
			REG_END_FRAME:   prdata = {27'd0, end_frame_q};
			REG_FRAME_COUNT: prdata = {26'd0, frame_count_q};
			REG_BLEND_STEP:  prdata = {15'd0, blend_step_q};
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_frame_q <= 5'd0;
			end_frame_q   <= 5'd1;
			frame_count_q <= 6'd32;
			blend_step_q  <= '0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_START_FRAME: start_frame_q <= pwdata[4:0];
				REG_END_FRAME:   end_frame_q   <= pwdata[4:0];
				REG_FRAME_COUNT: frame_count_q <= pwdata[5:0];
				REG_BLEND_STEP:  blend_step_q  <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	// Vertex reads: even steps fetch the current frame, odd steps the next one.
	always_comb begin
		case (cnt_q[2:1])
			2'd0:    fetch_vert = tri_q[56:48];
			2'd1:    fetch_vert = tri_q[47:39];
			default: fetch_vert = tri_q[38:30];
		endcase
		fetch_frame = cnt_q[0] ? nxt_frame_q : cur_frame_q;
		case (cnt_q[1:0])
			2'd0:    fetch_tex = tri_q[29:20];
			2'd1:    fetch_tex = tri_q[19:10];
			default: fetch_tex = tri_q[9:0];
		endcase
		if (state_q == S_IDLE) begin
			vaddr = VAW'(32'(frame) * VERTICES + 32'(index));
			vok   = (32'(frame) < FRAMES) && (32'(index) < VERTICES);
		end else begin
			vaddr = VAW'(32'(fetch_frame) * VERTICES + 32'(fetch_vert));
			vok   = (32'(fetch_frame) < FRAMES) && (32'(fetch_vert) < VERTICES);
		end
		case (ecnt_q)
			2'd0:    corner = 2'd0;
			2'd1:    corner = 2'd2;
			default: corner = 2'd1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && command == CMD_LOAD_VERTEX && vok)
			vmem[vaddr] <= {value_x, value_y, value_z};
		vrd_q <= vmem[vaddr];
		vok_q <= vok;
	end

	always_ff @(posedge clk) begin
		if (accept && command == CMD_LOAD_TEXCOORD && 32'(index) < TEXCOORDS)
			cmem[CAW'(index)] <= {value_x[15:0], value_y[15:0]};
		crd_q <= cmem[CAW'(fetch_tex)];
		cok_q <= 32'(fetch_tex) < TEXCOORDS;
	end

	always_ff @(posedge clk) begin
		if (accept && command == CMD_LOAD_TRIANGLE && 32'(index) < TRIANGLES)
			tmem[TAW'(index)] <= {vert_a, vert_b, vert_c, tex_a, tex_b, tex_c};
		trd_q <= tmem[TAW'(index)];
	end

	// Data captures along the draw sequence.
	always_ff @(posedge clk) begin
		if (state_q == S_TRI)
			tri_q <= trd_q;
		if (state_q == S_FETCH && cnt_q != 3'd0) begin
			if (cnt_q[0] == 1'b1)
				p1_q[2'((cnt_q - 3'd1) >> 1)] <= vok_q ? vrd_q : '0;
			else
				p2_q[2'((cnt_q - 3'd1) >> 1)] <= vok_q ? vrd_q : '0;
		end
		if (state_q == S_NORM && cnt_q != 3'd0 && cnt_q < 3'd4)
			tc_q[2'(cnt_q - 3'd1)] <= cok_q ? crd_q : '0;
	end

	// Control sequencer, animation state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			ecnt_q       <= '0;
			cur_frame_q  <= 5'd0;
			nxt_frame_q  <= 5'd1;
			blend_q      <= '0;
			status_q     <= 1'b0;
			norm_start_q <= 1'b0;
			out_valid    <= 1'b0;
		end else begin
			norm_start_q <= 1'b0;
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (command)
							CMD_BEGIN_PASS: begin
								logic [5:0] cf, nf;
								cf = {1'b0, (start_frame_q > cur_frame_q) ? start_frame_q
									: cur_frame_q};
								cur_frame_q <= cf[4:0];
								state_q     <= S_BEGIN;
								if ({1'b0, start_frame_q} >= frame_count_q
									|| {1'b0, end_frame_q} >= frame_count_q) begin
									status_q <= 1'b1;
								end else begin
									status_q <= 1'b0;
									if (blend_q >= BLEND_ONE) begin
										blend_q <= '0;
										cf = cf + 6'd1;
										if (cf >= {1'b0, end_frame_q})
											cf = {1'b0, start_frame_q};
										nf = cf + 6'd1;
										if (nf >= {1'b0, end_frame_q})
											nf = {1'b0, start_frame_q};
										cur_frame_q <= cf[4:0];
										nxt_frame_q <= nf[4:0];
									end
								end
							end
							CMD_END_PASS: begin
								logic [18:0] sum;
								sum = {1'b0, blend_q} + {2'b0, blend_step_q};
								blend_q <= sum[18] ? BLEND_MAX : sum[17:0];
							end
							CMD_DRAW: begin
								if (32'(index) < TRIANGLES)
									state_q <= S_TRI;
							end
							default: ;
						endcase
					end
				end
				S_TRI: begin
					state_q <= S_FETCH;
					cnt_q   <= '0;
				end
				S_FETCH: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd6) begin
						state_q <= S_LERP;
						cnt_q   <= '0;
					end
				end
				S_LERP: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd2) begin
						state_q      <= S_NORM;
						norm_start_q <= 1'b1;
						cnt_q        <= '0;
					end
				end
				S_NORM: begin
					if (cnt_q < 3'd4)
						cnt_q <= cnt_q + 3'd1;
					if (norm_done && cnt_q == 3'd4) begin
						state_q <= S_EMIT;
						ecnt_q  <= '0;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						pos_x      <= pos[corner][2];
						pos_y      <= pos[corner][1];
						pos_z      <= pos[corner][0];
						tex_s      <= tc_q[corner][31:16];
						tex_t      <= tc_q[corner][15:0];
						norm_x     <= nres.nx;
						norm_y     <= nres.ny;
						norm_z     <= nres.nz;
						degenerate <= nres.degen;
						status     <= 1'b0;
						last       <= (ecnt_q == 2'd2);
						ecnt_q     <= ecnt_q + 2'd1;
						if (ecnt_q == 2'd2)
							state_q <= S_IDLE;
					end
				end
				S_BEGIN: begin
					if (out_free) begin
						out_valid  <= 1'b1;
						pos_x      <= '0;
						pos_y      <= '0;
						pos_z      <= '0;
						tex_s      <= '0;
						tex_t      <= '0;
						norm_x     <= '0;
						norm_y     <= '0;
						norm_z     <= '0;
						degenerate <= 1'b0;
						status     <= status_q;
						last       <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Three corner lanes; vectors are stored x in the top slot.
	for (genvar g = 0; g < 3; g++) begin : g_lane
		vec3_t lp1, lp2;
		assign lp1 = {p1_q[g][0], p1_q[g][1], p1_q[g][2]};
		assign lp2 = {p2_q[g][0], p2_q[g][1], p2_q[g][2]};
		vec3_t lpos;
		kvm_lane u_lane (
			.clk   (clk),
			.blend (blend_q),
			.p1    (lp1),
			.p2    (lp2),
			.pos   (lpos)
		);
		assign pos[g] = {lpos[0], lpos[1], lpos[2]};
	end

	kvm_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start_q),
		.p0     ({pos[0][0], pos[0][1], pos[0][2]}),
		.p1     ({pos[1][0], pos[1][1], pos[1][2]}),
		.p2     ({pos[2][0], pos[2][1], pos[2][2]}),
		.done   (norm_done),
		.res    (nres)
	);

`ifndef SYNTHESIS
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> last)
		else $error("range status on a result that is not the last");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> norm_x == '0 && norm_y == '0 && norm_z == '0)
		else $error("degenerate result with a nonzero normal");
	a_norm_done: assert property (@(posedge clk) disable iff (!arst_n)
		norm_done |-> state_q == S_NORM)
		else $error("normal unit finished outside a draw");
`endif

endmodule
